// ----- rtl/mpdm_pkg.sv -----
// Shared types, sizes and codes of the multi-pattern DFA matcher.
package mpdm_pkg;

  localparam int NUM_DFAS              = 2;
  localparam int NUM_STATES            = 1024;
  localparam int MAX_MATCHES_PER_STATE = 8;
  localparam int SYMBOLS               = 256;
  localparam int QUEUE_DEPTH           = 2;

  localparam int DFA_W      = $clog2(NUM_DFAS);
  localparam int STATE_W    = $clog2(NUM_STATES);
  localparam int SLOT_W     = $clog2(MAX_MATCHES_PER_STATE);
  localparam int CNT_W      = $clog2(MAX_MATCHES_PER_STATE + 1);
  localparam int SYM_W      = $clog2(SYMBOLS);
  localparam int ROW_W      = DFA_W + STATE_W;
  localparam int TRANS_AW   = ROW_W + SYM_W;
  localparam int ML_AW      = ROW_W + SLOT_W;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths of the stream payload.
  localparam int OPCODE_W       = 2;
  localparam int LOAD_STATE_W   = 10;
  localparam int LOAD_SLOT_W    = 3;
  localparam int PATTERN_W      = 16;
  localparam int LOAD_COUNT_W   = 4;
  localparam int IN_DATA_W      = 56;
  localparam int IN_USER_W      = 4;
  localparam int OUT_DATA_W     = 16;

  localparam logic [OPCODE_W-1:0] OPC_SCAN     = 2'd0;
  localparam logic [OPCODE_W-1:0] OPC_WR_TRANS = 2'd1;
  localparam logic [OPCODE_W-1:0] OPC_WR_COUNT = 2'd2;
  localparam logic [OPCODE_W-1:0] OPC_WR_MATCH = 2'd3;

  typedef struct packed {
    logic [4:0]              pad;
    logic [LOAD_COUNT_W-1:0] load_count;
    logic [PATTERN_W-1:0]    load_pattern;
    logic [LOAD_SLOT_W-1:0]  load_slot;
    logic [LOAD_STATE_W-1:0] load_next_state;
    logic [LOAD_STATE_W-1:0] load_state;
    logic [SYM_W-1:0]        data_byte;
  } in_data_t;

  typedef struct packed {
    logic                start_of_packet;
    logic                dfa_select;
    logic [OPCODE_W-1:0] opcode;
  } in_user_t;

  typedef enum logic [2:0] {
    OP_SCAN,
    OP_TRANS,
    OP_COUNT,
    OP_MATCH,
    OP_SKIP
  } op_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_t                     op;
    logic [DFA_W-1:0]        dfa;
    logic                    sop;
    logic [SYM_W-1:0]        sym;
    logic [STATE_W-1:0]      state;
    logic [LOAD_STATE_W-1:0] next_state;
    logic [SLOT_W-1:0]       slot;
    logic [PATTERN_W-1:0]    pattern;
    logic [CNT_W-1:0]        count;
  } entry_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_STEP,
    BS_COUNT,
    BS_EMIT
  } back_state_t;

endpackage

// ----- rtl/mpdm_front.sv -----
// Front end: accepts stream items, classifies them and queues them for the back end.
module mpdm_front import mpdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  input  logic                 accept_en,
  output logic                 q_valid,
  output entry_t               q_entry,
  input  logic                 q_pop
);

  entry_t             q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  q_cnt_r, q_cnt_nxt;
  in_data_t           din;
  in_user_t           uin;
  entry_t             cls;
  logic               push, pop, state_ok, slot_ok;

  assign din = in_data_t'(in_tdata);
  assign uin = in_user_t'(in_tuser);

  assign in_tready = accept_en && (q_cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (q_cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_entry   = q_mem_r[rd_ptr_r];

  assign state_ok = ({1'b0, din.load_state} < (LOAD_STATE_W + 1)'(NUM_STATES));
  assign slot_ok  = ({1'b0, din.load_slot} < (LOAD_SLOT_W + 1)'(MAX_MATCHES_PER_STATE));

  always_comb begin
    cls.dfa        = DFA_W'(uin.dfa_select % NUM_DFAS);
    cls.sop        = uin.start_of_packet;
    cls.sym        = din.data_byte;
    cls.state      = STATE_W'(din.load_state);
    cls.next_state = din.load_next_state;
    cls.slot       = SLOT_W'(din.load_slot);
    cls.pattern    = din.load_pattern;
    // Counts above the list length saturate as they are written.
    if (32'(din.load_count) > MAX_MATCHES_PER_STATE) begin
      cls.count = CNT_W'(MAX_MATCHES_PER_STATE);
    end else begin
      cls.count = CNT_W'(din.load_count);
    end
    unique case (uin.opcode)
      OPC_SCAN:     cls.op = OP_SCAN;
      OPC_WR_TRANS: cls.op = state_ok ? OP_TRANS : OP_SKIP;
      OPC_WR_COUNT: cls.op = state_ok ? OP_COUNT : OP_SKIP;
      OPC_WR_MATCH: cls.op = (state_ok && slot_ok) ? OP_MATCH : OP_SKIP;
      default:      cls.op = OP_SKIP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (q_cnt_r == $past(q_cnt_r) + QCNT_W'(1)))
    else $error("queue fill count did not follow a push");

endmodule

// ----- rtl/mpdm_back.sv -----
// Back end: table memories, DFA stepping and the match-list read-out.
module mpdm_back import mpdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  entry_t                q_entry,
  output logic                  q_pop,
  output logic                  accept_en,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [LOAD_STATE_W-1:0] trans_mem [NUM_DFAS * NUM_STATES * SYMBOLS];
  logic [CNT_W-1:0]        cnt_mem   [NUM_DFAS * NUM_STATES];
  logic [PATTERN_W-1:0]    ml_mem    [NUM_DFAS * NUM_STATES * MAX_MATCHES_PER_STATE];

  back_state_t             state_r, state_nxt;
  logic [STATE_W-1:0]      cur_state_r, cur_state_nxt;
  logic [DFA_W-1:0]        cur_dfa_r, cur_dfa_nxt;
  logic [SLOT_W-1:0]       k_r, k_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ROW_W-1:0]        clr_idx_r, clr_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PATTERN_W-1:0]    out_pat_r, out_pat_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    trans_re, trans_we;
  logic [TRANS_AW-1:0]     trans_raddr, trans_waddr;
  logic [LOAD_STATE_W-1:0] trans_rdata_r;
  logic                    cnt_re, cnt_we;
  logic [ROW_W-1:0]        cnt_raddr, cnt_waddr;
  logic [CNT_W-1:0]        cnt_wdata, cnt_rdata_r;
  logic                    ml_re, ml_we;
  logic [ML_AW-1:0]        ml_raddr, ml_waddr;
  logic [PATTERN_W-1:0]    ml_rdata_r;

  logic [DFA_W-1:0]        scan_dfa;
  logic [STATE_W-1:0]      scan_state, step_state;
  logic                    is_last, out_free;

  assign accept_en  = (state_r != BS_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pat_r;
  assign out_tlast  = out_last_r;

  assign scan_dfa   = q_entry.sop ? q_entry.dfa : cur_dfa_r;
  assign scan_state = q_entry.sop ? '0 : cur_state_r;
  assign step_state = STATE_W'(trans_rdata_r % NUM_STATES);
  assign is_last    = ((CNT_W'(k_r) + CNT_W'(1)) == cnt_r);
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cur_state_nxt = cur_state_r;
    cur_dfa_nxt   = cur_dfa_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pat_nxt   = out_pat_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    trans_re      = 1'b0;
    trans_raddr   = {scan_dfa, scan_state, q_entry.sym};
    trans_we      = 1'b0;
    trans_waddr   = {q_entry.dfa, q_entry.state, q_entry.sym};
    cnt_re        = 1'b0;
    cnt_raddr     = {cur_dfa_r, step_state};
    cnt_we        = 1'b0;
    cnt_waddr     = {q_entry.dfa, q_entry.state};
    cnt_wdata     = q_entry.count;
    ml_re         = 1'b0;
    ml_raddr      = {cur_dfa_r, step_state, SLOT_W'(0)};
    ml_we         = 1'b0;
    ml_waddr      = {q_entry.dfa, q_entry.state, q_entry.slot};

    unique case (state_r)
      BS_CLEAR: begin
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        cnt_wdata   = '0;
        clr_idx_nxt = clr_idx_r + ROW_W'(1);
        if (clr_idx_r == ROW_W'(NUM_DFAS * NUM_STATES - 1)) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_entry.op)
            OP_SCAN: begin
              trans_re      = 1'b1;
              cur_dfa_nxt   = scan_dfa;
              cur_state_nxt = scan_state;
              state_nxt     = BS_STEP;
            end
            OP_TRANS: trans_we = 1'b1;
            OP_COUNT: cnt_we   = 1'b1;
            OP_MATCH: ml_we    = 1'b1;
            default: ;
          endcase
        end
      end
      BS_STEP: begin
        // The count and the first list entry are fetched together.
        cur_state_nxt = step_state;
        cnt_re        = 1'b1;
        ml_re         = 1'b1;
        state_nxt     = BS_COUNT;
      end
      BS_COUNT: begin
        cnt_nxt = cnt_rdata_r;
        k_nxt   = '0;
        state_nxt = (cnt_rdata_r == '0) ? BS_IDLE : BS_EMIT;
      end
      BS_EMIT: begin
        // The list entry held in the read register goes out once the
        // output register is free; the next entry is fetched meanwhile.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pat_nxt   = ml_rdata_r;
          out_last_nxt  = is_last;
          if (is_last) begin
            state_nxt = BS_IDLE;
          end else begin
            k_nxt    = k_r + SLOT_W'(1);
            ml_re    = 1'b1;
            ml_raddr = {cur_dfa_r, cur_state_r, k_r + SLOT_W'(1)};
          end
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      cur_state_r <= '0;
      cur_dfa_r   <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_state_r <= cur_state_nxt;
      cur_dfa_r   <= cur_dfa_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pat_r  <= out_pat_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= q_entry.next_state;
    end
    if (trans_re) begin
      trans_rdata_r <= trans_mem[trans_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ml_we) begin
      ml_mem[ml_waddr] <= q_entry.pattern;
    end
    if (ml_re) begin
      ml_rdata_r <= ml_mem[ml_raddr];
    end
  end

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_EMIT) |-> (CNT_W'(k_r) < cnt_r))
    else $error("match-list index beyond the state's count");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_COUNT) |-> (32'(cnt_rdata_r) <= MAX_MATCHES_PER_STATE))
    else $error("stored match count above the list length");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_CLEAR) |-> (!out_valid_r && !q_pop))
    else $error("activity during the count clearing pass");

endmodule

// ----- rtl/multi_pattern_dfa_matcher.sv -----
// Top level of the multi-pattern DFA matcher: front end, item queue and back end.
// A scan item is written into the queue on the edge that accepts it. The back end
// then reads its transition, then the count and first list entry of the new state
// together, then latches the count and moves each match into the output register.
// It takes no new queue item until the scan's matches have all entered the output
// register. Reset: synchronous, active low; a clearing pass over all 2048 count entries
// follows, during which in_tready stays low.
module multi_pattern_dfa_matcher import mpdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Bits from the lowest up: data_byte, load_state, load_next_state, load_slot,
  // load_pattern, load_count, then zero padding.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Bits from the lowest up: opcode, dfa_select, start_of_packet.
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Bits from the lowest up: matched_pattern.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // The last match reported for the scanned byte.
  output logic                  out_tlast
);

  // The front end decodes each item into a queue entry, dropping loads that
  // address a state or a list slot outside the tables. The back end owns the
  // transition table, the per-state match counts and the match lists, and
  // walks the automaton one scanned byte at a time.
  logic   q_valid;
  logic   q_pop;
  logic   accept_en;
  entry_t q_entry;

  mpdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .accept_en (accept_en),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  // Matches are checked after each step, so a pattern that ends on the final
  // byte of a packet is still reported. Results leave through a single output
  // register, so a stalled sink holds the walk without losing an item.
  mpdm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .accept_en  (accept_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- sim/tb_multi_pattern_dfa_matcher.sv -----
// Self-checking testbench of the multi-pattern DFA matcher: table loads, packet scans, stalls.
module tb_multi_pattern_dfa_matcher import mpdm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 32;

  typedef struct {
    logic [PATTERN_W-1:0] pattern;
    logic                 last;
  } pattern_hit_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // Own copy of the matcher tables and scan position.
  bit [STATE_W-1:0]   trans_mem [int];
  bit [CNT_W-1:0]     count_mem [NUM_DFAS*NUM_STATES];
  bit [PATTERN_W-1:0] match_mem [int];
  bit [STATE_W-1:0]   cur_state;
  bit                 cur_dfa;

  pattern_hit_t expected_hits [$];
  int           failures       = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_requests  = 0;
  int           hold_served    = 0;
  int           hold_left      = 0;

  // States of each DFA that the random walk is built on.
  int pool [NUM_DFAS][$];

  multi_pattern_dfa_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  function automatic int row_index(input logic dfa, input logic [STATE_W-1:0] st);
    return int'(dfa) * NUM_STATES + int'(st);
  endfunction

  // Number of match-list slots written from slot zero up without a hole.
  function automatic int listed_slots(input logic dfa, input logic [STATE_W-1:0] st);
    int row;
    int n;
    row = row_index(dfa, st);
    n = 0;
    while (n < MAX_MATCHES_PER_STATE && match_mem.exists(row * MAX_MATCHES_PER_STATE + n))
      n++;
    return n;
  endfunction

  // A symbol leaving this state through a written transition into a state whose
  // reported matches are all written; returns 0 when there is none.
  function automatic bit pick_symbol(input logic dfa, input logic [STATE_W-1:0] st,
                                     output logic [SYM_W-1:0] sym);
    int               row;
    int               key;
    logic [STATE_W-1:0] nxt;
    logic [SYM_W-1:0] options [$];
    row = row_index(dfa, st);
    for (int s = 0; s < SYMBOLS; s++) begin
      key = row * SYMBOLS + s;
      if (trans_mem.exists(key)) begin
        nxt = trans_mem[key];
        if (count_mem[row_index(dfa, nxt)] <= listed_slots(dfa, nxt))
          options.push_back(SYM_W'(s));
      end
    end
    sym = '0;
    if (options.size() == 0)
      return 0;
    sym = options[$urandom_range(options.size() - 1)];
    return 1;
  endfunction

  // Steps the predicted matcher by one accepted item and queues the hits it reports.
  function automatic void advance_matcher(input in_user_t u, input in_data_t d);
    int           row;
    int           n;
    pattern_hit_t hit;
    if (u.opcode == OPC_SCAN) begin
      if (u.start_of_packet) begin
        cur_dfa   = u.dfa_select;
        cur_state = '0;
      end
      row = row_index(cur_dfa, cur_state);
      cur_state = STATE_W'(int'(trans_mem[row * SYMBOLS + int'(d.data_byte)]) % NUM_STATES);
      row = row_index(cur_dfa, cur_state);
      n = count_mem[row];
      for (int k = 0; k < n; k++) begin
        hit.pattern = match_mem[row * MAX_MATCHES_PER_STATE + k];
        hit.last    = (k == n - 1);
        expected_hits.push_back(hit);
      end
    end else if (d.load_state < NUM_STATES) begin
      row = row_index(u.dfa_select, d.load_state);
      case (u.opcode)
        OPC_WR_TRANS: begin
          trans_mem[row * SYMBOLS + int'(d.data_byte)] = d.load_next_state;
        end
        OPC_WR_COUNT: begin
          count_mem[row] = (d.load_count > MAX_MATCHES_PER_STATE) ?
                           CNT_W'(MAX_MATCHES_PER_STATE) : d.load_count;
        end
        default: begin
          if (d.load_slot < MAX_MATCHES_PER_STATE)
            match_mem[row * MAX_MATCHES_PER_STATE + int'(d.load_slot)] = d.load_pattern;
        end
      endcase
    end
  endfunction

  // Offers one item, with random idle cycles in front, and predicts it once taken.
  task automatic send_item(input in_user_t u, input in_data_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= u;
    do @(posedge clk); while (!in_tready);
    advance_matcher(u, d);
  endtask

  // Fields an item does not use carry random bits.
  function automatic in_data_t random_payload();
    logic [63:0] bits;
    in_data_t    d;
    bits  = {$urandom, $urandom};
    d     = bits[IN_DATA_W-1:0];
    d.pad = '0;
    return d;
  endfunction

  function automatic in_user_t make_user(input logic [OPCODE_W-1:0] op, input logic dfa,
                                         input logic sop);
    in_user_t u;
    u.opcode          = op;
    u.dfa_select      = dfa;
    u.start_of_packet = sop;
    return u;
  endfunction

  task automatic write_transition(input logic dfa, input logic [LOAD_STATE_W-1:0] st,
                                  input logic [SYM_W-1:0] sym,
                                  input logic [LOAD_STATE_W-1:0] nxt);
    in_data_t d;
    d = random_payload();
    d.load_state      = st;
    d.data_byte       = sym;
    d.load_next_state = nxt;
    send_item(make_user(OPC_WR_TRANS, dfa, 1'($urandom)), d);
  endtask

  task automatic write_match_count(input logic dfa, input logic [LOAD_STATE_W-1:0] st,
                                   input logic [LOAD_COUNT_W-1:0] cnt);
    in_data_t d;
    d = random_payload();
    d.load_state = st;
    d.load_count = cnt;
    send_item(make_user(OPC_WR_COUNT, dfa, 1'($urandom)), d);
  endtask

  task automatic write_match_entry(input logic dfa, input logic [LOAD_STATE_W-1:0] st,
                                   input logic [LOAD_SLOT_W-1:0] slot,
                                   input logic [PATTERN_W-1:0] pat);
    in_data_t d;
    d = random_payload();
    d.load_state   = st;
    d.load_slot    = slot;
    d.load_pattern = pat;
    send_item(make_user(OPC_WR_MATCH, dfa, 1'($urandom)), d);
  endtask

  task automatic scan_symbol(input logic sop, input logic dfa, input logic [SYM_W-1:0] sym);
    in_data_t d;
    d = random_payload();
    d.data_byte = sym;
    send_item(make_user(OPC_SCAN, dfa, sop), d);
  endtask

  // A count never above the written list prefix once saturated, so no scan reads a hole.
  task automatic write_safe_count(input logic dfa, input logic [STATE_W-1:0] st);
    int n;
    n = listed_slots(dfa, st);
    if (n == MAX_MATCHES_PER_STATE && $urandom_range(1))
      write_match_count(dfa, st, LOAD_COUNT_W'($urandom_range(MAX_MATCHES_PER_STATE, 15)));
    else
      write_match_count(dfa, st, LOAD_COUNT_W'($urandom_range(n)));
  endtask

  // Next byte of a walk through the loaded automaton; a dead end starts a new packet.
  task automatic scan_walk(input logic sop, input logic dfa);
    logic [SYM_W-1:0] sym;
    logic             restart;
    restart = sop;
    if (!restart && !pick_symbol(cur_dfa, cur_state, sym))
      restart = 1'b1;
    if (restart)
      void'(pick_symbol(dfa, '0, sym));
    scan_symbol(restart, dfa, sym);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_hits.size() != 0);
  endtask

  // Extremes of every field, a saturated count, a cleared count, a byte scanned
  // before any start flag, and matches reported on the last byte of a packet.
  task automatic test_directed_tables();
    logic [PATTERN_W-1:0] pat;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_transition(1'b0, 10'd0, 8'h00, 10'd0);
    write_match_entry(1'b0, 10'd5, 3'd0, 16'hFFFF);
    write_match_count(1'b0, 10'd5, 4'd1);
    write_transition(1'b0, 10'd0, 8'h80, 10'd5);
    write_transition(1'b0, 10'd5, 8'hFF, 10'd5);
    for (int k = 0; k < MAX_MATCHES_PER_STATE; k++) begin
      pat = (k == 0) ? 16'h0000 : (k == 7) ? 16'hFFFF : PATTERN_W'($urandom);
      write_match_entry(1'b1, 10'd1023, LOAD_SLOT_W'(k), pat);
    end
    write_match_count(1'b1, 10'd1023, 4'd15);
    write_transition(1'b1, 10'd0, 8'hFF, 10'd1023);
    write_transition(1'b1, 10'd1023, 8'h00, 10'd1023);
    // No start flag yet: the scan runs from the reset DFA and root.
    scan_symbol(1'b0, 1'($urandom), 8'h00);
    scan_symbol(1'b0, 1'($urandom), 8'h80);
    scan_symbol(1'b0, 1'($urandom), 8'hFF);
    scan_symbol(1'b1, 1'b1, 8'hFF);
    scan_symbol(1'b0, 1'($urandom), 8'h00);
    write_match_count(1'b0, 10'd5, 4'd0);
    scan_symbol(1'b1, 1'b0, 8'h80);
  endtask

  // Random automata in both DFAs, then packets walking them under each idling mix,
  // with a few stray loads and DFA switches mixed in.
  task automatic test_random_traffic();
    int phase_idle [4];
    int phase_stall [4];
    int n;
    int r;
    logic dfa;
    logic [STATE_W-1:0] st;
    phase_idle  = '{0, 47, 0, 12};
    phase_stall = '{0, 0, 47, 12};
    for (int d = 0; d < NUM_DFAS; d++) begin
      pool[d].push_back(0);
      repeat (6) pool[d].push_back($urandom_range(1, NUM_STATES - 1));
      for (int i = 0; i < pool[d].size(); i++) begin
        n = ($urandom_range(3) == 0) ? MAX_MATCHES_PER_STATE : $urandom_range(3);
        for (int k = 0; k < n; k++)
          write_match_entry(1'(d), LOAD_STATE_W'(pool[d][i]), LOAD_SLOT_W'(k),
                            PATTERN_W'($urandom));
        write_safe_count(1'(d), STATE_W'(pool[d][i]));
      end
      for (int i = 0; i < pool[d].size(); i++)
        repeat (3)
          write_transition(1'(d), LOAD_STATE_W'(pool[d][i]), SYM_W'($urandom),
                           LOAD_STATE_W'(pool[d][$urandom_range(pool[d].size() - 1)]));
    end
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      repeat (45) begin
        r   = $urandom_range(99);
        dfa = 1'($urandom);
        if (r < 10) begin
          case ($urandom_range(2))
            0: write_transition(dfa, LOAD_STATE_W'(pool[dfa][$urandom_range(pool[dfa].size() - 1)]),
                                SYM_W'($urandom),
                                LOAD_STATE_W'(pool[dfa][$urandom_range(pool[dfa].size() - 1)]));
            1: write_match_entry(dfa, LOAD_STATE_W'($urandom), LOAD_SLOT_W'($urandom),
                                 PATTERN_W'($urandom));
            default: begin
              st = ($urandom_range(1)) ? STATE_W'($urandom)
                                       : STATE_W'(pool[dfa][$urandom_range(pool[dfa].size() - 1)]);
              write_safe_count(dfa, st);
            end
          endcase
        end else begin
          scan_walk(r < 25, dfa);
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while packets keep coming, so the
  // block backs up and holds in_tready low.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (30) scan_walk($urandom_range(3) == 0, 1'($urandom));
    wait_drained();
  endtask

  // Bursts of packets, each followed by a pause until every hit has come out.
  task automatic test_drain_pause();
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    repeat (3) begin
      repeat (10) scan_walk($urandom_range(4) == 0, 1'($urandom));
      wait_drained();
    end
  endtask

  // Receiver: checks each accepted result against the oldest expected hit and
  // decides out_tready for the next edge.
  always @(posedge clk) begin
    pattern_hit_t hit;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result, pattern %h last %b", $time, out_tdata, out_tlast);
        failures++;
      end else begin
        hit = expected_hits.pop_front();
        if (out_tdata !== hit.pattern) begin
          $display("%0t: matched_pattern expected %h, got %h", $time, hit.pattern, out_tdata);
          failures++;
        end
        if (out_tlast !== hit.last) begin
          $display("%0t: last_match expected %b, got %b", $time, hit.last, out_tlast);
          failures++;
        end
      end
    end
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends the run when nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_tables();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && expected_hits.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
